/* hw/rtl/servo_bus_packet_framer_top_assert.svh */
// assertion macros shared by the framer modules
`ifndef SERVO_BUS_PACKET_FRAMER_TOP_ASSERT_SVH
`define SERVO_BUS_PACKET_FRAMER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SBPF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbpf assertion failed");

// next-cycle implication, checked outside reset
`define SBPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbpf assertion failed");

`endif

/* hw/rtl/sbpf_pkg.sv */
package sbpf_pkg;

  // frame constants
  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam int MAX_PARAMS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // input item kinds carried on tuser
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_PARAM = 1'b1
  } cmd_t;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic       is_start;   // header entry, else parameter entry
    logic [7:0] data;       // servo id on start, parameter byte otherwise
    logic [7:0] length;     // length byte, start only
    logic [7:0] instr;      // instruction byte, start only
    logic [7:0] checksum;   // checksum byte if this entry closes the frame
    logic       close;      // entry ends with the checksum byte
  } entry_t;

  // byte slots of the back sequencer
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_HDR0  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_HDR1  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ID    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LEN   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_INSTR = 3'd4;
  localparam logic [STEP_W-1:0] STEP_CKSUM = 3'd5;

endpackage

/* hw/rtl/sbpf_front.sv */
`include "servo_bus_packet_framer_top_assert.svh"

module sbpf_front #(
  parameter int MAX_PARAMS = sbpf_pkg::MAX_PARAMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  sbpf_pkg::cmd_t     cmd,
  input  logic [7:0]         target_addr,
  input  logic [7:0]         instruction,
  input  logic [7:0]         param_count,
  input  logic [7:0]         param_byte,
  output logic               push,
  output sbpf_pkg::entry_t   push_entry
);

  localparam int CNT_W = $clog2(MAX_PARAMS + 1);
  localparam logic [7:0] MAX_P8 = 8'(MAX_PARAMS);

  logic             frame_open_r, frame_open_nxt;
  logic [CNT_W-1:0] params_left_r, params_left_nxt;
  logic [7:0]       running_sum_r, running_sum_nxt;

  logic [7:0] cnt_clamped;
  logic [7:0] len_byte;
  logic [7:0] start_sum;
  logic [7:0] param_sum;
  logic       last_param;

  // header arithmetic for a start item
  assign cnt_clamped = (param_count > MAX_P8) ? MAX_P8 : param_count;
  assign len_byte    = 8'd2 + cnt_clamped;
  assign start_sum   = target_addr + len_byte + instruction;
  assign param_sum   = running_sum_r + param_byte;
  assign last_param  = (params_left_r == CNT_W'(1));

  // classify the item and update the frame state
  always_comb begin
    frame_open_nxt  = frame_open_r;
    params_left_nxt = params_left_r;
    running_sum_nxt = running_sum_r;
    push            = 1'b0;
    push_entry      = '0;
    if (in_fire) begin
      unique case (cmd)
        sbpf_pkg::CMD_START: begin
          push                = 1'b1;
          push_entry.is_start = 1'b1;
          push_entry.data     = target_addr;
          push_entry.length   = len_byte;
          push_entry.instr    = instruction;
          push_entry.checksum = ~start_sum;
          push_entry.close    = (cnt_clamped == 8'd0);
          running_sum_nxt     = start_sum;
          params_left_nxt     = cnt_clamped[CNT_W-1:0];
          frame_open_nxt      = (cnt_clamped != 8'd0);
        end
        sbpf_pkg::CMD_PARAM: begin
          if (!frame_open_r || params_left_r == '0) begin
            frame_open_nxt = 1'b0;
          end else begin
            push                = 1'b1;
            push_entry.is_start = 1'b0;
            push_entry.data     = param_byte;
            push_entry.checksum = ~param_sum;
            push_entry.close    = last_param;
            running_sum_nxt     = param_sum;
            params_left_nxt     = params_left_r - CNT_W'(1);
            if (last_param) begin
              frame_open_nxt = 1'b0;
            end
          end
        end
        default: begin
          frame_open_nxt = frame_open_r;
        end
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r  <= 1'b0;
      params_left_r <= '0;
      running_sum_r <= '0;
    end else begin
      frame_open_r  <= frame_open_nxt;
      params_left_r <= params_left_nxt;
      running_sum_r <= running_sum_nxt;
    end
  end

  // an open frame always expects at least one more parameter
  `SBPF_ASSERT_IMPL(a_open_has_params, clk, rst_n, frame_open_r, params_left_r != '0)
  // a closing parameter leaves no frame open
  `SBPF_ASSERT_NEXT(a_close_clears_open, clk, rst_n, push && push_entry.close, !frame_open_r)

endmodule

/* hw/rtl/sbpf_queue.sv */
`include "servo_bus_packet_framer_top_assert.svh"

module sbpf_queue #(
  parameter int DEPTH = sbpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sbpf_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output sbpf_pkg::entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sbpf_pkg::entry_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  `SBPF_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full || pop)
  `SBPF_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, count_r != '0)

endmodule

/* hw/rtl/sbpf_back.sv */
`include "servo_bus_packet_framer_top_assert.svh"

module sbpf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  sbpf_pkg::entry_t head,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);

  logic [sbpf_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [sbpf_pkg::STEP_W-1:0] last_step;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r, out_byte_nxt;
  logic                        frame_end_r, frame_end_nxt;
  logic                        load;
  logic                        at_last;

  // last byte slot of the head entry
  always_comb begin
    if (head.is_start) begin
      last_step = head.close ? sbpf_pkg::STEP_CKSUM : sbpf_pkg::STEP_INSTR;
    end else begin
      last_step = head.close ? sbpf_pkg::STEP_HDR1 : sbpf_pkg::STEP_HDR0;
    end
  end

  assign load    = head_valid && (!out_valid_r || out_tready);
  assign at_last = (step_r == last_step);
  assign pop     = load && at_last;

  // pick the byte for the current slot
  always_comb begin
    out_byte_nxt  = out_byte_r;
    frame_end_nxt = frame_end_r;
    out_valid_nxt = out_valid_r && !out_tready;
    step_nxt      = step_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      frame_end_nxt = head.close && at_last;
      step_nxt      = at_last ? '0 : step_r + sbpf_pkg::STEP_W'(1);
      if (head.is_start) begin
        unique case (step_r)
          sbpf_pkg::STEP_HDR0:  out_byte_nxt = sbpf_pkg::HDR_BYTE;
          sbpf_pkg::STEP_HDR1:  out_byte_nxt = sbpf_pkg::HDR_BYTE;
          sbpf_pkg::STEP_ID:    out_byte_nxt = head.data;
          sbpf_pkg::STEP_LEN:   out_byte_nxt = head.length;
          sbpf_pkg::STEP_INSTR: out_byte_nxt = head.instr;
          default:              out_byte_nxt = head.checksum;
        endcase
      end else begin
        out_byte_nxt = (step_r == sbpf_pkg::STEP_HDR0) ? head.data : head.checksum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    frame_end_r <= frame_end_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = frame_end_r;

  // the slot counter never runs past the head entry
  `SBPF_ASSERT_IMPL(a_step_bound, clk, rst_n, head_valid, step_r <= last_step)
  // slot counter rests at zero between entries
  `SBPF_ASSERT_NEXT(a_step_rewind, clk, rst_n, pop, step_r == '0)

endmodule

/* hw/rtl/servo_bus_packet_framer_top.sv */
// Servo-bus instruction frame builder. A start transfer (in_tuser = 0) produces the
// bytes 0xFF, 0xFF, id, length (2 plus the count clamped to MAX_PARAMS) and
// instruction, followed by the checksum with out_tlast set when the count is zero.
// Each parameter transfer (in_tuser = 1) of an open frame produces its byte, plus
// the checksum with out_tlast after the last expected parameter; other parameters
// are dropped, and a start abandons any open frame. The input side takes one
// transfer per cycle while the QUEUE_DEPTH-entry queue between the classifier and
// the byte sequencer has room; the output side sends one byte per cycle while
// out_tready is high; a start yields 5 or 6 bytes and a parameter 1 or 2, so the byte
// sequencer sets the sustained rate.
module servo_bus_packet_framer_top #(
  parameter int MAX_PARAMS  = sbpf_pkg::MAX_PARAMS_DEF,
  parameter int QUEUE_DEPTH = sbpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // target_addr, instruction, param_count, param_byte
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast
);

  logic             in_fire;
  logic             q_full;
  logic             push;
  sbpf_pkg::entry_t push_entry;
  logic             pop;
  logic             head_valid;
  sbpf_pkg::entry_t head;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // classify incoming transfers
  sbpf_front #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .cmd         (sbpf_pkg::cmd_t'(in_tuser)),
    .target_addr (in_tdata[7:0]),
    .instruction (in_tdata[15:8]),
    .param_count (in_tdata[23:16]),
    .param_byte  (in_tdata[31:24]),
    .push        (push),
    .push_entry  (push_entry)
  );

  // decoupling queue
  sbpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // byte sequencer
  sbpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
